// ===== src/vrr_pkg.sv =====
// Shared types, constants and helpers of the voxel ray remover.
`default_nettype none
package vrr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int GRID_CELLS = 32;
  localparam int CW         = 5;              // cell coordinate bits
  localparam int SW         = 6;              // size register bits
  localparam int OW         = 26;             // origin bits
  localparam int DW         = 18;             // direction bits
  localparam int TW         = 38;             // ray parameter and position bits
  localparam int NW         = TW + 1;         // divider numerator bits
  localparam int QB         = 37;             // quotient bits worked out per divide
  localparam int MEM_AW     = 3 * CW;
  localparam int IDW        = 8;              // voxel id bits
  localparam int CIW        = 2;              // config index bits

  localparam logic signed [TW-1:0] T_SAT = 38'sh10_0000_0000;
  localparam logic signed [TW-1:0] T_INF = 38'sh10_0000_0001;
  localparam int T_EPS_I = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic signed [TW-1:0] T_EPS = TW'(T_EPS_I);

  // Config register indexes
  localparam logic [CIW-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CIW-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CIW-1:0] CFG_SIZE_Z = 2'd2;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SLAB0, S_W0, S_SLAB1, S_W1,
    S_MUL, S_CELL, S_CHECK, S_TEST, S_W2, S_RESULT
  } vrr_state_t;

  typedef struct packed {
    logic                 start;
    logic signed [NW-1:0] num;
    logic signed [DW-1:0] den;
  } div_req_t;

  // Saturate a wide signed value to +-T_SAT
  function automatic logic signed [TW-1:0] sat_t(input logic signed [TW+2:0] v);
    logic signed [TW+2:0] lim;
    lim = {3'b000, T_SAT};
    if (v > lim) return T_SAT;
    else if (v < -lim) return -T_SAT;
    else return v[TW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/vrr_cfg_if.sv =====
// Configuration write channel.
`default_nettype none
interface vrr_cfg_if import vrr_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [CIW-1:0] index;
  logic [SW-1:0]  data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/vrr_in_if.sv =====
// Input item channel: voxel write or ray cast.
`default_nettype none
interface vrr_in_if import vrr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [CW-1:0]        cell_x;
  logic [CW-1:0]        cell_y;
  logic [CW-1:0]        cell_z;
  logic [IDW-1:0]       voxel_id;
  logic signed [OW-1:0] origin_x;
  logic signed [OW-1:0] origin_y;
  logic signed [OW-1:0] origin_z;
  logic signed [DW-1:0] dir_x;
  logic signed [DW-1:0] dir_y;
  logic signed [DW-1:0] dir_z;

  modport source(output valid, output func, output cell_x, output cell_y, output cell_z,
                 output voxel_id, output origin_x, output origin_y, output origin_z,
                 output dir_x, output dir_y, output dir_z, input ready);
  modport sink(input valid, input func, input cell_x, input cell_y, input cell_z,
               input voxel_id, input origin_x, input origin_y, input origin_z,
               input dir_x, input dir_y, input dir_z, output ready);
endinterface
`default_nettype wire

// ===== src/vrr_out_if.sv =====
// Result item channel.
`default_nettype none
interface vrr_out_if import vrr_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          hit;
  logic [CW-1:0] hit_x;
  logic [CW-1:0] hit_y;
  logic [CW-1:0] hit_z;

  modport source(output valid, output hit, output hit_x, output hit_y, output hit_z,
                 input ready);
  modport sink(input valid, input hit, input hit_x, input hit_y, input hit_z,
               output ready);
endinterface
`default_nettype wire

// ===== src/vrr_div.sv =====
// Radix-2 restoring divider giving a saturated, truncated ray distance.
`default_nettype none
module vrr_div import vrr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_req_t             req,
  output logic                 busy,
  output logic signed [TW-1:0] quo
);

  localparam int CNTW = $clog2(QB + 1);
  localparam int LOB  = QB - FRAC_BITS;   // numerator bits below the first partial remainder

  logic            busy_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [QB-1:0]   sh_r;
  logic            neg_r;
  logic            ovf_r;

  logic [NW-1:0]   num_abs;
  logic [DW-1:0]   den_abs;
  logic [NW-LOB-2:0] num_top;
  logic [DW+1:0]   diff;
  logic            ge;
  logic [TW-1:0]   mag;

  // Magnitudes of the operands
  always_comb begin
    num_abs = req.num[NW-1] ? NW'(-req.num) : NW'(req.num);
    den_abs = req.den[DW-1] ? DW'(-req.den) : DW'(req.den);
    num_top = num_abs[NW-2:LOB];
  end

  // One quotient bit per cycle
  assign diff = {1'b0, rem_r, sh_r[QB-1]} - {2'b00, den_r};
  assign ge   = !diff[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(QB);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNTW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DW'(num_top);
      den_r <= den_abs;
      sh_r  <= {num_abs[LOB-1:0], {FRAC_BITS{1'b0}}};
      neg_r <= req.num[NW-1] ^ req.den[DW-1];
      ovf_r <= ({{(DW-(NW-LOB-1)){1'b0}}, num_top} >= den_abs);
    end else if (busy_r) begin
      rem_r <= ge ? diff[DW-1:0] : {rem_r[DW-2:0], sh_r[QB-1]};
      sh_r  <= {sh_r[QB-2:0], ge};
    end
  end

  // Saturate and apply sign
  always_comb begin
    if (ovf_r || ({1'b0, sh_r} > TW'(T_SAT))) mag = TW'(T_SAT);
    else mag = {1'b0, sh_r};
    quo = neg_r ? -$signed(mag) : $signed(mag);
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ===== src/voxel_ray_remove.sv =====
// Voxel ID store with a ray-cast remover that walks the grid cell by cell.
//
// Channels: cfg_ch writes size_x/size_y/size_z (index 0..2) and is always ready;
// write configuration only while the block is idle. in_ch takes one item at a
// time; out_ch returns exactly one result item per input item.
// A write item updates the store on acceptance and yields a miss result. A
// cast item runs two slab divides, a multiply pass over the three axes to
// place the start point, then per visited cell: one range check, one memory
// read, one divide and a multiply pass over the three axes. The walk visits
// up to MAX_STEPS cells. The three per-axis dividers (one quotient bit a
// cycle) set the pace. After reset the store is swept to zero, one entry a
// cycle, over all 32768 entries; in_ch.ready stays low until the sweep ends.
// Size registers reset to 32.
// A finished result waits in an output register; while it is not taken, the
// next item is still accepted, and its own result waits until the register
// frees.
`default_nettype none
module voxel_ray_remove import vrr_pkg::*; #(
  parameter int MAX_STEPS = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  vrr_cfg_if.sink   cfg_ch,
  vrr_in_if.sink    in_ch,
  vrr_out_if.source out_ch
);

  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int PW     = 2 * DW + 2;         // partial product bits
  localparam int FW     = PW + 19;            // full product bits

  vrr_state_t state_r, state_nxt;

  // Store
  logic [IDW-1:0]    mem [2**MEM_AW];
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa, mem_ra;
  logic [IDW-1:0]    mem_wd, rd_r;
  logic [MEM_AW-1:0] clr_r;

  // Config and ray state
  logic [SW-1:0]        size_r [3];
  logic [SW-1:0]        sz_eff [3];
  logic signed [OW-1:0] o_r [3];
  logic signed [DW-1:0] d_r [3];
  logic signed [TW-1:0] pos_r [3];
  logic signed [TW-1:0] t0_r [3];
  logic signed [6:0]    cell_r [3];
  logic [STEP_W-1:0]    step_r;
  logic signed [TW-1:0] tcur_r;
  logic                 init_r;
  logic [1:0]           ax_r, sub_r;
  logic signed [PW-1:0] plo_r, phi_r;

  // Pending and output result
  logic          res_hit_r;
  logic [CW-1:0] res_x_r, res_y_r, res_z_r;
  logic          out_vld_r, out_hit_r;
  logic [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic          out_load;

  // Dividers
  div_req_t             div_req [3];
  logic [2:0]           div_busy;
  logic signed [TW-1:0] dq [3];

  // Combinational helpers
  logic signed [TW-1:0] slab_lo [3], slab_hi [3];
  logic signed [OW:0]   hib [3];
  logic signed [TW-1:0] tmin, tmax, t_start;
  logic                 clip_miss;
  logic signed [TW-1:0] tn [3];
  logic [1:0]           sel;
  logic signed [TW-1:0] ts;
  logic signed [19:0]   mul_b;
  logic signed [PW-1:0] prod;
  logic signed [FW-1:0] mfull;
  logic signed [TW+2:0] mfl, mbase, msum;
  logic signed [21:0]   cpos [3];
  logic [SW-1:0]        szm1 [3];
  logic signed [6:0]    cclamp [3];
  logic                 out_of_grid;
  logic signed [7:0]    nbc [3];
  logic                 cast_acc, write_acc;

  assign cast_acc  = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_CAST);
  assign write_acc = in_ch.valid && in_ch.ready && (in_ch.func == FUNC_WRITE);

  // Effective grid size per axis
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (size_r[a] == '0) sz_eff[a] = SW'(1);
      else if (size_r[a] > SW'(GRID_CELLS)) sz_eff[a] = SW'(GRID_CELLS);
      else sz_eff[a] = size_r[a];
      szm1[a] = sz_eff[a] - SW'(1);
      hib[a]  = $signed({{(OW+1-SW-FRAC_BITS){1'b0}}, sz_eff[a], {FRAC_BITS{1'b0}}});
    end
  end

  // Slab clip from both distance passes
  always_comb begin
    tmin      = -T_SAT;
    tmax      = T_SAT;
    clip_miss = 1'b0;
    for (int a = 0; a < 3; a++) begin
      slab_lo[a] = (t0_r[a] > dq[a]) ? dq[a] : t0_r[a];
      slab_hi[a] = (t0_r[a] > dq[a]) ? t0_r[a] : dq[a];
      if (d_r[a] == '0) begin
        if (o_r[a] < 0 || o_r[a] > hib[a]) clip_miss = 1'b1;
      end else begin
        if (slab_lo[a] > tmin) tmin = slab_lo[a];
        if (slab_hi[a] < tmax) tmax = slab_hi[a];
      end
    end
    if (tmax < tmin || tmax < 0) clip_miss = 1'b1;
    t_start = (tmin > T_EPS) ? tmin : T_EPS;
  end

  // Pick the axis with the nearest boundary
  always_comb begin
    for (int a = 0; a < 3; a++) tn[a] = (d_r[a] == '0) ? T_INF : dq[a];
    if (tn[0] < tn[1] && tn[0] < tn[2]) sel = 2'd0;
    else if (tn[1] < tn[2]) sel = 2'd1;
    else sel = 2'd2;
    ts = (tn[sel] > T_SAT) ? T_SAT : tn[sel];
  end

  // Shared multiplier: low half, high half, then accumulate into position
  always_comb begin
    mul_b = (sub_r == 2'd0) ? $signed({1'b0, tcur_r[18:0]})
                            : $signed({tcur_r[TW-1], tcur_r[TW-1:19]});
    prod  = d_r[ax_r] * mul_b;
    mfull = ($signed({{19{phi_r[PW-1]}}, phi_r}) <<< 19)
          + $signed({{19{plo_r[PW-1]}}, plo_r});
    mfl   = mfull[FW-1:FRAC_BITS];
    mbase = init_r ? $signed({{(TW+3-OW){o_r[ax_r][OW-1]}}, o_r[ax_r]})
                   : $signed({{3{pos_r[ax_r][TW-1]}}, pos_r[ax_r]});
    msum  = mbase + mfl;
  end

  // First cell, clamped into the grid; boundary cells for the next step
  always_comb begin
    out_of_grid = 1'b0;
    for (int a = 0; a < 3; a++) begin
      cpos[a] = pos_r[a][TW-1:FRAC_BITS];
      if (cpos[a] < 0) cclamp[a] = '0;
      else if (cpos[a] > $signed({16'b0, szm1[a]})) cclamp[a] = $signed({1'b0, szm1[a]});
      else cclamp[a] = cpos[a][6:0];
      if (cell_r[a] < 0 || cell_r[a] >= $signed({1'b0, sz_eff[a]})) out_of_grid = 1'b1;
      nbc[a] = $signed({cell_r[a][6], cell_r[a]}) + (d_r[a][DW-1] ? 8'sd0 : 8'sd1);
    end
  end

  // Divider requests
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      div_req[a].den   = d_r[a];
      div_req[a].start = (state_r == S_SLAB0) || (state_r == S_SLAB1)
                      || (state_r == S_TEST && rd_r == '0);
      unique case (state_r)
        S_SLAB1: div_req[a].num = $signed({{(NW-OW-FRAC_BITS-SW+OW){1'b0}}, sz_eff[a],
                                          {FRAC_BITS{1'b0}}})
                                - $signed({{(NW-OW){o_r[a][OW-1]}}, o_r[a]});
        S_TEST:  div_req[a].num = $signed({{15{nbc[a][7]}}, nbc[a], {FRAC_BITS{1'b0}}})
                                - $signed({pos_r[a][TW-1], pos_r[a]});
        default: div_req[a].num = -$signed({{(NW-OW){o_r[a][OW-1]}}, o_r[a]});
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    vrr_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (div_req[g]),
      .busy  (div_busy[g]),
      .quo   (dq[g])
    );
  end

  // Store ports: sweep, item write, clear on hit
  always_comb begin
    mem_ra = {cell_r[2][CW-1:0], cell_r[1][CW-1:0], cell_r[0][CW-1:0]};
    mem_we = 1'b0;
    mem_wa = mem_ra;
    mem_wd = '0;
    if (state_r == S_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
    end else if (write_acc) begin
      mem_we = 1'b1;
      mem_wa = {in_ch.cell_z, in_ch.cell_y, in_ch.cell_x};
      mem_wd = in_ch.voxel_id;
    end else if (state_r == S_TEST && rd_r != '0) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (cast_acc) state_nxt = S_SLAB0;
        else if (write_acc) state_nxt = S_RESULT;
      end
      S_SLAB0:  state_nxt = S_W0;
      S_W0:     if (div_busy == '0) state_nxt = S_SLAB1;
      S_SLAB1:  state_nxt = S_W1;
      S_W1:     if (div_busy == '0) state_nxt = clip_miss ? S_RESULT : S_MUL;
      S_MUL:    if (sub_r == 2'd2 && ax_r == 2'd2) state_nxt = init_r ? S_CELL : S_CHECK;
      S_CELL:   state_nxt = S_CHECK;
      S_CHECK:  state_nxt = (step_r == STEP_W'(MAX_STEPS) || out_of_grid) ? S_RESULT : S_TEST;
      S_TEST:   state_nxt = (rd_r != '0) ? S_RESULT : S_W2;
      S_W2:     if (div_busy == '0) state_nxt = S_MUL;
      S_RESULT: if (!out_vld_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign out_load = (state_r == S_RESULT) && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= '0;
      step_r    <= '0;
      out_vld_r <= 1'b0;
      for (int a = 0; a < 3; a++) size_r[a] <= SW'(GRID_CELLS);
    end else begin
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == S_CELL) step_r <= '0;
      else if (state_r == S_W2 && div_busy == '0) step_r <= step_r + 1'b1;
      if (out_load) out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
      // Register writes
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_SIZE_X: size_r[0] <= cfg_ch.data;
          CFG_SIZE_Y: size_r[1] <= cfg_ch.data;
          CFG_SIZE_Z: size_r[2] <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r <= res_hit_r;
      out_x_r   <= res_x_r;
      out_y_r   <= res_y_r;
      out_z_r   <= res_z_r;
    end
    unique case (state_r)
      S_IDLE: begin
        res_hit_r <= 1'b0;
        res_x_r   <= '0;
        res_y_r   <= '0;
        res_z_r   <= '0;
        if (cast_acc) begin
          o_r[0] <= in_ch.origin_x;
          o_r[1] <= in_ch.origin_y;
          o_r[2] <= in_ch.origin_z;
          d_r[0] <= in_ch.dir_x;
          d_r[1] <= in_ch.dir_y;
          d_r[2] <= in_ch.dir_z;
        end
      end
      S_W0: begin
        if (div_busy == '0) for (int a = 0; a < 3; a++) t0_r[a] <= dq[a];
      end
      S_W1: begin
        tcur_r <= t_start;
        init_r <= 1'b1;
        ax_r   <= 2'd0;
        sub_r  <= 2'd0;
      end
      S_MUL: begin
        unique case (sub_r)
          2'd0: plo_r <= prod;
          2'd1: phi_r <= prod;
          default: pos_r[ax_r] <= sat_t(msum);
        endcase
        if (sub_r == 2'd2) begin
          sub_r <= 2'd0;
          ax_r  <= ax_r + 2'd1;
        end else begin
          sub_r <= sub_r + 2'd1;
        end
      end
      S_CELL: begin
        for (int a = 0; a < 3; a++) cell_r[a] <= cclamp[a];
      end
      S_TEST: begin
        if (rd_r != '0) begin
          res_hit_r <= 1'b1;
          res_x_r   <= cell_r[0][CW-1:0];
          res_y_r   <= cell_r[1][CW-1:0];
          res_z_r   <= cell_r[2][CW-1:0];
        end
      end
      S_W2: begin
        // Step into the chosen neighbor and advance along the ray
        if (div_busy == '0) begin
          cell_r[sel] <= cell_r[sel] + (d_r[sel][DW-1] ? -7'sd1 : 7'sd1);
          tcur_r      <= ts;
          init_r      <= 1'b0;
          ax_r        <= 2'd0;
          sub_r       <= 2'd0;
        end
      end
      default: ;
    endcase
  end

  // Ports
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_vld_r;
  assign out_ch.hit   = out_hit_r;
  assign out_ch.hit_x = out_x_r;
  assign out_ch.hit_y = out_y_r;
  assign out_ch.hit_z = out_z_r;

`ifndef SYNTHESIS
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_ch.ready)
    else $error("item accepted during store sweep");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (step_r <= STEP_W'(MAX_STEPS)))
    else $error("walk step count past limit");

  a_hit_reported: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TEST && rd_r != '0) |=> (state_r == S_RESULT && res_hit_r))
    else $error("non-empty voxel not reported");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.hit) |-> (out_ch.hit_x == '0 && out_ch.hit_y == '0
                                       && out_ch.hit_z == '0))
    else $error("miss result carries a cell");
`endif

endmodule
`default_nettype wire
